// ===== hw/rtl/aids_pkg.sv =====
// shared types, codes and defaults for the array insert/delete/search block
package aids_pkg;

    localparam int DEPTH_DEF = 64;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;     // latch the accepted input beat
        logic do_op;       // run insert/delete/read and load its result
        logic load_match;  // load the search match vector
        logic emit_scan;   // emit one search result
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_search;
        logic out_free;
        logic scan_done;
    } dp_stat_t;

endpackage

// ===== hw/rtl/aids_ctrl.sv =====
// controller state machine for the array insert/delete/search block
module aids_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  aids_pkg::dp_stat_t stat,
    output aids_pkg::dp_cmd_t  ctl
);
    import aids_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.is_search)
                begin
                    state_next = S_SCAN;
                end
                else if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (stat.out_free && stat.scan_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall       = 1'b1;
        ctl.capture    = 1'b0;
        ctl.do_op      = 1'b0;
        ctl.load_match = 1'b0;
        ctl.emit_scan  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall    = 1'b0;
                ctl.capture = in_valid;
            end
            S_EXEC:
            begin
                ctl.load_match = stat.is_search;
                ctl.do_op      = !stat.is_search && stat.out_free;
            end
            S_SCAN:
            begin
                ctl.emit_scan = stat.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== hw/rtl/aids_dp.sv =====
// datapath: entry cells, count, match vector and result register
module aids_dp #(
    parameter int DEPTH = aids_pkg::DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  aids_pkg::dp_cmd_t  ctl,
    output aids_pkg::dp_stat_t stat,
    input  logic [1:0]         cmd,
    input  logic [5:0]         position,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [5:0]         found_index,
    output logic signed [31:0] read_value,
    output logic [6:0]         entry_count,
    output logic               last
);
    import aids_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t               cmd_reg;
    logic [5:0]         pos_reg;
    logic [31:0]        key_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [31:0]        cells_reg [DEPTH];
    logic [31:0]        shift_up [DEPTH];
    logic [31:0]        shift_dn [DEPTH];
    logic [DEPTH-1:0]   match_reg;
    logic [DEPTH-1:0]   match_next;
    logic [DEPTH-1:0]   match_low;
    logic [DEPTH-1:0]   match_rest;
    logic [IDX_W-1:0]   low_idx;
    logic [IDX_W-1:0]   pos_idx;

    logic               out_valid_reg;
    status_t            status_reg;
    logic [5:0]         index_reg;
    logic [31:0]        value_reg;
    logic [6:0]         count_out_reg;
    logic               last_reg;

    logic [6:0]         cnt7;
    logic [6:0]         pos7;
    status_t            op_status;
    logic [5:0]         op_index;
    logic [31:0]        op_value;
    logic [6:0]         op_count;
    logic               wr_ins;
    logic               wr_del;

    assign cnt7    = 7'(count_reg);
    assign pos7    = {1'b0, pos_reg};
    assign pos_idx = pos_reg[IDX_W-1:0];

    // neighbor taps for the shift
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_tap
        if (i == 0)
        begin : g_first
            assign shift_up[i] = key_reg;
        end
        else
        begin : g_up
            assign shift_up[i] = cells_reg[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_top
            assign shift_dn[i] = cells_reg[i];
        end
        else
        begin : g_dn
            assign shift_dn[i] = cells_reg[i+1];
        end
    end

    // insert, delete and read decode
    always_comb
    begin
        op_status = ST_OK;
        op_index  = '0;
        op_value  = '0;
        op_count  = cnt7;
        wr_ins    = 1'b0;
        wr_del    = 1'b0;
        unique case (cmd_reg)
            CMD_INSERT:
            begin
                if (cnt7 == 7'(DEPTH))
                begin
                    op_status = ST_FULL;
                end
                else if (pos7 > cnt7)
                begin
                    op_status = ST_RANGE;
                end
                else
                begin
                    wr_ins   = 1'b1;
                    op_count = cnt7 + 7'd1;
                end
            end
            CMD_DELETE:
            begin
                if (pos7 >= cnt7)
                begin
                    op_status = ST_RANGE;
                end
                else
                begin
                    wr_del   = 1'b1;
                    op_count = cnt7 - 7'd1;
                end
            end
            CMD_SEARCH:
            begin
                op_status = ST_OK;
            end
            CMD_READ:
            begin
                if (pos7 >= cnt7)
                begin
                    op_status = ST_RANGE;
                end
                else
                begin
                    op_index = pos_reg;
                    op_value = cells_reg[pos_idx];
                end
            end
            default:
            begin
                op_status = ST_OK;
            end
        endcase
    end

    assign count_next = op_count[CNT_W-1:0];

    // per-cell compare against the key
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            match_next[i] = (cells_reg[i] == key_reg) && (7'(i) < cnt7);
        end
    end

    assign match_low  = match_reg & (~match_reg + {{(DEPTH-1){1'b0}}, 1'b1});
    assign match_rest = match_reg & (match_reg - {{(DEPTH-1){1'b0}}, 1'b1});

    always_comb
    begin
        low_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (match_low[i])
            begin
                low_idx = low_idx | IDX_W'(i);
            end
        end
    end

    assign stat.is_search = (cmd_reg == CMD_SEARCH);
    assign stat.out_free  = !out_valid_reg || !out_stall;
    assign stat.scan_done = (match_rest == '0);

    // input beat capture
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= cmd_t'(cmd);
            pos_reg <= position;
            key_reg <= value;
        end
    end

    // entry cells
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (ctl.do_op && wr_ins)
            begin
                if (7'(i) == pos7)
                begin
                    cells_reg[i] <= key_reg;
                end
                else if (7'(i) > pos7)
                begin
                    cells_reg[i] <= shift_up[i];
                end
            end
            else if (ctl.do_op && wr_del)
            begin
                if (7'(i) >= pos7)
                begin
                    cells_reg[i] <= shift_dn[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            match_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.do_op)
            begin
                count_reg <= count_next;
            end
            if (ctl.load_match)
            begin
                match_reg <= match_next;
            end
            else if (ctl.emit_scan)
            begin
                match_reg <= match_rest;
            end
            if (ctl.do_op || ctl.emit_scan)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ctl.do_op)
        begin
            status_reg    <= op_status;
            index_reg     <= op_index;
            value_reg     <= op_value;
            count_out_reg <= op_count;
            last_reg      <= 1'b1;
        end
        else if (ctl.emit_scan)
        begin
            count_out_reg <= cnt7;
            if (match_reg == '0)
            begin
                status_reg <= ST_NOTFOUND;
                index_reg  <= '0;
                value_reg  <= '0;
                last_reg   <= 1'b1;
            end
            else
            begin
                status_reg <= ST_OK;
                index_reg  <= 6'(low_idx);
                value_reg  <= key_reg;
                last_reg   <= (match_rest == '0);
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_index = index_reg;
    assign read_value  = value_reg;
    assign entry_count = count_out_reg;
    assign last        = last_reg;

endmodule

// ===== hw/rtl/array_insert_delete_search.sv =====
// top level: ordered array with insert, delete, linear search and read
// insert, delete or read: the beat is captured, then its result is loaded once the output is free
// search: the beat is captured and the match vector loaded, then one result per cycle while not stalled
// items do not overlap: a new beat is taken only in idle, after the last item's results are loaded, set by
// the controller sequence idle -> execute -> scan around the single result register
// reset: rst_n clears the entry count, the match vector, the controller and the result valid; the entry cells
// are not cleared and need no clearing pass, since only written positions are ever read
module array_insert_delete_search #(
    parameter int DEPTH = aids_pkg::DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [5:0]         position,
    input  logic signed [31:0] value,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [5:0]         found_index,
    output logic signed [31:0] read_value,
    output logic [6:0]         entry_count,
    output logic               last
);
    import aids_pkg::*;

    dp_cmd_t  ctl;
    dp_stat_t stat;

    // sequencing: idle takes a beat, execute does the op or loads the match vector,
    // scan walks the matches lowest position first
    aids_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctl      (ctl)
    );

    // cells at and above the position shift on insert and delete; search compares all cells at once
    aids_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .cmd         (cmd),
        .position    (position),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .found_index (found_index),
        .read_value  (read_value),
        .entry_count (entry_count),
        .last        (last)
    );

    // count never runs past the array size
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (entry_count <= 7'(DEPTH)))
        else $error("entry count above depth");

    // a not-found result always closes its item
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_NOTFOUND)) |-> last)
        else $error("not-found result without last");

    // only search matches come in runs, and they are all ok
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (status == ST_OK))
        else $error("non-final result with bad status");

    // once a match run has started the next beat follows without a gap
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=> out_valid)
        else $error("gap inside a search result run");

endmodule

// ===== verif/tb.sv =====
// testbench for array_insert_delete_search: random insert/delete/search/read traffic with a mirror
`timescale 1ns / 1ps

module tb;
    import aids_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int QUIET_TAIL = 30;      // last commands go out with no idling on either side
    localparam int DRAIN      = 10;      // cycles after the last reply, well past the latency
    localparam int LIMIT      = 1500000; // 180 commands x 64 replies, each reply held by output stalls, 6x over

    // one command as it goes on the wire
    typedef struct {
        cmd_t        op;
        logic [5:0]  pos;
        logic [31:0] val;
    } array_cmd_t;

    // one reply beat, field for field
    typedef struct {
        status_t            status;
        logic [5:0]         idx;
        logic signed [31:0] val;
        logic [6:0]         cnt;
        logic               last;
    } array_reply_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         cmd = 2'd0;
    logic [5:0]         position = 6'd0;
    logic signed [31:0] value = 32'sd0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic [5:0]         found_index;
    logic signed [31:0] read_value;
    logic [6:0]         entry_count;
    logic               last;

    // commands waiting to be driven, and replies the mirror says are owed
    array_cmd_t   pending_cmds[$];
    array_reply_t array_replies[$];

    // mirror of the array contents
    logic [31:0] mirror_cells[DEPTH];
    int          mirror_count;

    // count as the command generator sees it, used only to aim positions
    int gen_count;

    // bookkeeping for the summary and the verdict
    int cmd_seen[4];
    int status_seen[4];
    int widest_search;
    int beats_checked;
    int mismatch_count;
    int cycle_count;

    // driver and monitor burst state
    int         idle_left;
    int         stall_left;
    array_cmd_t next_cmd;

    // values that repeat often, so searches hit many positions
    logic [31:0] value_pool[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0005};

    array_insert_delete_search #(.DEPTH(DEPTH)) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .position    (position),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .found_index (found_index),
        .read_value  (read_value),
        .entry_count (entry_count),
        .last        (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // work out the replies one accepted command causes and update the mirror
    task automatic apply_array_cmd(input array_cmd_t c);
        array_reply_t r;
        int           i;
        int           hits;
        int           top;
        r = '{status: ST_OK, idx: 6'd0, val: 32'sd0, cnt: 7'd0, last: 1'b1};
        hits = 0;
        top = -1;
        cmd_seen[c.op]++;
        case (c.op)
            CMD_INSERT:
            begin
                // full is checked before the position
                if (mirror_count == DEPTH)
                    r.status = ST_FULL;
                else if (int'(c.pos) > mirror_count)
                    r.status = ST_RANGE;
                else
                begin
                    for (i = mirror_count; i > int'(c.pos); i--)
                        mirror_cells[i] = mirror_cells[i - 1];
                    mirror_cells[c.pos] = c.val;
                    mirror_count++;
                end
                r.cnt = mirror_count[6:0];
                array_replies.push_back(r);
                status_seen[r.status]++;
            end
            CMD_DELETE:
            begin
                if (int'(c.pos) >= mirror_count)
                    r.status = ST_RANGE;
                else
                begin
                    for (i = c.pos; i + 1 < mirror_count; i++)
                        mirror_cells[i] = mirror_cells[i + 1];
                    mirror_count--;
                end
                r.cnt = mirror_count[6:0];
                array_replies.push_back(r);
                status_seen[r.status]++;
            end
            CMD_SEARCH:
            begin
                for (i = 0; i < mirror_count; i++)
                    if (mirror_cells[i] == c.val)
                        top = i;
                r.cnt = mirror_count[6:0];
                if (top < 0)
                begin
                    // nothing matched, empty array included
                    r.status = ST_NOTFOUND;
                    array_replies.push_back(r);
                    status_seen[ST_NOTFOUND]++;
                end
                else
                begin
                    // one beat per match in ascending order, last only on the highest
                    for (i = 0; i <= top; i++)
                        if (mirror_cells[i] == c.val)
                        begin
                            r.idx  = i[5:0];
                            r.val  = mirror_cells[i];
                            r.last = (i == top);
                            array_replies.push_back(r);
                            status_seen[ST_OK]++;
                            hits++;
                        end
                end
                if (hits > widest_search)
                    widest_search = hits;
            end
            default:
            begin
                if (int'(c.pos) >= mirror_count)
                    r.status = ST_RANGE;
                else
                begin
                    r.idx = c.pos;
                    r.val = mirror_cells[c.pos];
                end
                r.cnt = mirror_count[6:0];
                array_replies.push_back(r);
                status_seen[r.status]++;
            end
        endcase
    endtask

    // queue a command and track what it will do to the count
    task automatic queue_cmd(input cmd_t op, input int pos, input logic [31:0] val);
        array_cmd_t c;
        c.op  = op;
        c.pos = pos[5:0];
        c.val = val;
        pending_cmds.push_back(c);
        if (op == CMD_INSERT && gen_count < DEPTH && pos <= gen_count)
            gen_count++;
        else if (op == CMD_DELETE && pos < gen_count)
            gen_count--;
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 9) < 7)
            return value_pool[$urandom_range(0, 3)];
        return $urandom;
    endfunction

    // one random command; weights are percent for insert, delete, search, rest is read
    task automatic queue_random(input int w_ins, input int w_del, input int w_srch);
        int   roll;
        int   pos;
        cmd_t op;
        roll = $urandom_range(0, 99);
        if (roll < w_ins)
            op = CMD_INSERT;
        else if (roll < w_ins + w_del)
            op = CMD_DELETE;
        else if (roll < w_ins + w_del + w_srch)
            op = CMD_SEARCH;
        else
            op = CMD_READ;
        // mostly legal positions, some anywhere in the 6-bit range
        if ($urandom_range(0, 9) == 0)
            pos = $urandom_range(0, 63);
        else if (op == CMD_INSERT)
            pos = (gen_count >= DEPTH) ? $urandom_range(0, 63) : $urandom_range(0, gen_count);
        else if (gen_count == 0)
            pos = $urandom_range(0, 63);
        else
            pos = $urandom_range(0, gen_count - 1);
        queue_cmd(op, pos, pick_value());
    endtask

    // driver: take the accepted beat into the mirror, then present the next command
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            cmd       <= CMD_INSERT;
            position  <= 6'd0;
            value     <= 32'sd0;
            idle_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                apply_array_cmd('{op: cmd_t'(cmd), pos: position, val: value});
            // a stalled beat holds as it is
            if (!in_valid || !in_stall)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
                begin
                    idle_left = $urandom_range(1, 18) - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    next_cmd = pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    cmd      <= next_cmd.op;
                    position <= next_cmd.pos;
                    value    <= next_cmd.val;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: check each reply beat against the oldest owed reply, stall in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                beats_checked++;
                if (array_replies.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: reply beat with none owed: ",
                                  "status %0d index %0d value %0d count %0d last %0b"},
                                 $realtime, status, found_index, read_value, entry_count,
                                 last);
                end
                else
                begin : compare
                    array_reply_t want;
                    want = array_replies.pop_front();
                    if (status !== want.status || found_index !== want.idx ||
                        read_value !== want.val || entry_count !== want.cnt ||
                        last !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("%0t: reply mismatch", $realtime);
                            $display({"    status %0d/%0d index %0d/%0d value %0d/%0d ",
                                      "count %0d/%0d last %0b/%0b (want/got)"},
                                     want.status, status, want.idx, found_index,
                                     want.val, read_value, want.cnt, entry_count,
                                     want.last, last);
                        end
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 18) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int i;
        gen_count = 0;
        mirror_count = 0;

        // directed: empty array cases first
        queue_cmd(CMD_SEARCH, 0, 32'h0000_0000);
        queue_cmd(CMD_READ, 0, 32'h0000_0000);
        queue_cmd(CMD_DELETE, 0, 32'h0000_0000);
        queue_cmd(CMD_INSERT, 1, 32'h0000_0005);     // beyond count
        // build 0, -1, min, max using append, front and middle inserts
        queue_cmd(CMD_INSERT, 0, 32'h8000_0000);
        queue_cmd(CMD_INSERT, 1, 32'h7fff_ffff);
        queue_cmd(CMD_INSERT, 0, 32'h0000_0000);
        queue_cmd(CMD_INSERT, 1, 32'hffff_ffff);
        queue_cmd(CMD_INSERT, 63, 32'h0000_0001);    // far beyond count
        for (i = 0; i < 5; i++)
            queue_cmd(CMD_READ, i, 32'h0000_0000);   // last one sits at the count
        queue_cmd(CMD_INSERT, 2, 32'h7fff_ffff);     // duplicate key
        queue_cmd(CMD_SEARCH, 0, 32'h7fff_ffff);     // two matches
        queue_cmd(CMD_SEARCH, 0, 32'h8000_0000);
        queue_cmd(CMD_SEARCH, 63, 32'h0000_0005);    // no match
        queue_cmd(CMD_DELETE, 0, 32'hffff_ffff);     // first entry
        queue_cmd(CMD_DELETE, 3, 32'h0000_0000);     // last entry
        queue_cmd(CMD_DELETE, 63, 32'h0000_0000);
        queue_cmd(CMD_READ, 63, 32'hffff_ffff);

        // random: grow until full and beyond, churn, then shrink
        for (i = 0; i < 100; i++)
            queue_random(85, 3, 8);
        for (i = 0; i < 30; i++)
            queue_random(25, 25, 30);
        for (i = 0; i < 28; i++)
            queue_random(10, 55, 20);

        repeat (9) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // every command taken, then every reply seen, then a short drain
        while (pending_cmds.size() != 0 || in_valid)
            @(posedge clk);
        while (array_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("ran %0d inserts, %0d deletes, %0d searches, %0d reads; %0d reply beats checked",
                 cmd_seen[CMD_INSERT], cmd_seen[CMD_DELETE], cmd_seen[CMD_SEARCH],
                 cmd_seen[CMD_READ], beats_checked);
        $display("replies ok/full/range/not-found %0d/%0d/%0d/%0d, most matches in one search %0d",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_RANGE],
                 status_seen[ST_NOTFOUND], widest_search);
        if (mismatch_count == 0 && array_replies.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
